>>> rtl/sli_pkg.sv
// Shared definitions for the sorted list intersection block.
// Request codes, field widths and the sequencer state type.
// No dependencies.
package sli_pkg;

   // request codes carried on req_type
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_FETCH  = 2'd2;
   localparam logic [1:0] REQ_NOP    = 2'd3;

   // fixed field widths
   localparam int REQ_TYPE_W   = 2;
   localparam int LIST_ID_W    = 3;
   localparam int KEY_W        = 64;
   localparam int MATCH_IDX_W  = 10;
   localparam int SHORT_LIST_W = 3;
   localparam int CSR_W        = 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_PICK,
      S_PROBE_RD,
      S_PROBE_WAIT,
      S_LIST_CHK,
      S_LIST_CMP,
      S_FINISH
   } sli_state_type;

endpackage

>>> rtl/sorted_list_intersection.sv
// Top level of the sorted list intersection block.
// Sequencer, list lengths and cursors, and the shared key compare.
// Depends on sli_pkg and sli_key_ram.
//
// Usage:
//  - Request channel: an item is taken at a clock edge with start high and
//    busy low. req_type selects clear, append, fetch or no operation.
//  - Result channel: every item gives one result, shown for one cycle with
//    rsp_valid high. The receiver cannot stall; results are never held.
//  - CSR channel: csr_valid/csr_ready write lists_in_use; ready while idle.
//    A write restarts any scan in progress.
//  - Clear and no-op: result in the cycle after the accept edge, busy stays
//    low, so these run one item per cycle.
//  - Append: one memory write, unless the id is out of range or the list is full.
//  - Fetch: data dependent. The first fetch after loading steps through the
//    lists in use in S_PICK to pick the shortest list. Each probe of that
//    list then passes S_PROBE_RD and S_PROBE_WAIT, visits each list in use
//    in S_LIST_CHK and S_LIST_CMP, steps cursors past smaller keys and ends
//    in S_FINISH, all on the single read port and the one 64-bit comparator.
//  - Reset (synchronous, active high): all lists empty, cursors zero,
//    lists_in_use zero. The key memory is not cleared; only entries below a
//    list's length are read.
module sorted_list_intersection #(
   parameter int MAX_LISTS  = 8,
   parameter int LIST_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [sli_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [sli_pkg::LIST_ID_W-1:0]     req_list_id,
   input  logic [sli_pkg::KEY_W-1:0]         req_key_value,
   // result channel
   output logic                              rsp_valid,
   output logic [sli_pkg::MATCH_IDX_W-1:0]   rsp_match_index,
   output logic [sli_pkg::SHORT_LIST_W-1:0]  rsp_shortest_list,
   output logic                              rsp_match_valid,
   output logic                              rsp_done_res,
   output logic                              rsp_overflow,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sli_pkg::CSR_W-1:0]         csr_data
);
   import sli_pkg::*;

   localparam int LW        = $clog2(MAX_LISTS);        // list index bits
   localparam int CW        = $clog2(MAX_LISTS + 1);    // list count bits
   localparam int PW        = $clog2(LIST_DEPTH);       // position bits
   localparam int LENW      = $clog2(LIST_DEPTH + 1);   // length bits
   localparam int AW        = LW + PW;
   localparam int MEM_DEPTH = MAX_LISTS * (1 << PW);

   sli_state_type state_ff, state_in;

   // architectural state
   logic [CSR_W-1:0] lists_in_use_ff, lists_in_use_in;
   logic [LENW-1:0]  len_ff [MAX_LISTS];
   logic [LENW-1:0]  len_in [MAX_LISTS];
   logic [LENW-1:0]  cur_ff [MAX_LISTS];
   logic [LENW-1:0]  cur_in [MAX_LISTS];
   logic [LW-1:0]    sid_ff, sid_in;
   logic [LENW-1:0]  slen_ff, slen_in;
   logic             started_ff, started_in;

   // sequencer working registers
   logic [CW-1:0]    sel_ff, sel_in;        // list under the sequencer
   logic [LENW-1:0]  pos_ff, pos_in;        // probe position in shortest list
   logic [KEY_W-1:0] probe_ff, probe_in;
   logic             all_eq_ff, all_eq_in;
   logic [KEY_W-1:0] key_ff, key_in;        // key of a pending append
   logic             id_bad_ff, id_bad_in;

   // result registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MATCH_IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [SHORT_LIST_W-1:0] rsp_sl_ff, rsp_sl_in;
   logic                    rsp_mv_ff, rsp_mv_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // memory port
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [AW-1:0]    ram_raddr;
   logic [KEY_W-1:0] ram_rdata;

   // decode
   logic            accept;
   logic            csr_wr;
   logic [CW-1:0]   n_use;
   logic            fetch_empty;
   logic [LENW-1:0] len_sel;
   logic [LENW-1:0] cur_sel;
   logic            sel_last;
   logic            sel_done;
   logic            key_lt;
   logic            key_eq;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign accept    = start && !busy;
   assign csr_wr    = csr_valid && csr_ready;

   // values above MAX_LISTS act as MAX_LISTS
   assign n_use = (32'(lists_in_use_ff) > MAX_LISTS) ? CW'(MAX_LISTS)
                                                     : CW'(lists_in_use_ff);

   // sel selects one length and cursor; the empty check reads all lengths
   assign len_sel  = len_ff[sel_ff[LW-1:0]];
   assign cur_sel  = cur_ff[sel_ff[LW-1:0]];
   assign sel_last = (CW'(sel_ff + 1'b1) >= n_use);
   assign sel_done = (sel_ff >= n_use);

   // the shared key comparator
   assign key_lt = (ram_rdata < probe_ff);
   assign key_eq = (ram_rdata == probe_ff);

   // a fetch with no lists, or with any list in use empty, ends at once
   always_comb begin
      fetch_empty = (n_use == '0);
      for (int i = 0; i < MAX_LISTS; i++) begin
         if ((CW'(i) < n_use) && (len_ff[i] == '0)) begin
            fetch_empty = 1'b1;
         end
      end
   end

   assign ram_raddr = {sel_ff[LW-1:0], cur_sel[PW-1:0]};
   assign ram_waddr = {sel_ff[LW-1:0], len_sel[PW-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_type == REQ_APPEND)) begin
               state_in = S_APPEND;
            end else if (accept && (req_type == REQ_FETCH) && !fetch_empty) begin
               state_in = started_ff ? S_PROBE_RD : S_PICK;
            end
         end
         S_APPEND: begin
            state_in = S_IDLE;
         end
         S_PICK: begin
            if (sel_done) begin
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            state_in = (cur_sel < slen_ff) ? S_PROBE_WAIT : S_IDLE;
         end
         S_PROBE_WAIT: begin
            state_in = S_LIST_CHK;
         end
         S_LIST_CHK: begin
            if (cur_sel >= len_sel) begin
               state_in = sel_last ? S_FINISH : S_LIST_CHK;
            end else begin
               state_in = S_LIST_CMP;
            end
         end
         S_LIST_CMP: begin
            if (key_lt) begin
               state_in = S_LIST_CHK;
            end else begin
               state_in = sel_last ? S_FINISH : S_LIST_CHK;
            end
         end
         S_FINISH: begin
            state_in = all_eq_ff ? S_IDLE : S_PROBE_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and results
   always_comb begin
      lists_in_use_in = lists_in_use_ff;
      len_in          = len_ff;
      cur_in          = cur_ff;
      sid_in          = sid_ff;
      slen_in         = slen_ff;
      started_in      = started_ff;
      sel_in          = sel_ff;
      pos_in          = pos_ff;
      probe_in        = probe_ff;
      all_eq_in       = all_eq_ff;
      key_in          = key_ff;
      id_bad_in       = id_bad_ff;
      ram_we          = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_idx_in      = '0;
      rsp_mv_in       = 1'b0;
      rsp_done_in     = 1'b0;
      rsp_ovf_in      = 1'b0;

      // register write restarts the scan
      if (csr_wr) begin
         lists_in_use_in = csr_data;
         for (int i = 0; i < MAX_LISTS; i++) begin
            cur_in[i] = '0;
         end
         started_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_CLEAR: begin
                     for (int i = 0; i < MAX_LISTS; i++) begin
                        len_in[i] = '0;
                        cur_in[i] = '0;
                     end
                     sid_in       = '0;
                     slen_in      = '0;
                     started_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  REQ_APPEND: begin
                     key_in    = req_key_value;
                     sel_in    = CW'(req_list_id);
                     id_bad_in = (32'(req_list_id) >= MAX_LISTS);
                  end
                  REQ_FETCH: begin
                     if (fetch_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_done_in  = 1'b1;
                     end else if (started_ff) begin
                        sel_in = CW'(sid_ff);
                     end else begin
                        // pick starts from list 0
                        sid_in  = '0;
                        slen_in = len_ff[0];
                        sel_in  = CW'(1);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_APPEND: begin
            if (id_bad_ff || (32'(len_sel) >= LIST_DEPTH)) begin
               rsp_ovf_in = 1'b1;
            end else begin
               ram_we                 = 1'b1;
               len_in[sel_ff[LW-1:0]] = len_sel + 1'b1;
            end
            for (int i = 0; i < MAX_LISTS; i++) begin
               cur_in[i] = '0;
            end
            started_in   = 1'b0;
            rsp_valid_in = 1'b1;
         end
         S_PICK: begin
            if (sel_done) begin
               for (int i = 0; i < MAX_LISTS; i++) begin
                  cur_in[i] = '0;
               end
               started_in = 1'b1;
               sel_in     = CW'(sid_ff);
            end else begin
               // strict less keeps the lowest id on a tie
               if (len_sel < slen_ff) begin
                  sid_in  = sel_ff[LW-1:0];
                  slen_in = len_sel;
               end
               sel_in = CW'(sel_ff + 1'b1);
            end
         end
         S_PROBE_RD: begin
            if (cur_sel < slen_ff) begin
               pos_in = cur_sel;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = 1'b1;
            end
         end
         S_PROBE_WAIT: begin
            probe_in  = ram_rdata;
            all_eq_in = 1'b1;
            sel_in    = '0;
         end
         S_LIST_CHK: begin
            if (cur_sel >= len_sel) begin
               all_eq_in = 1'b0;
               sel_in    = sel_last ? CW'(sid_ff) : CW'(sel_ff + 1'b1);
            end
         end
         S_LIST_CMP: begin
            if (key_lt) begin
               cur_in[sel_ff[LW-1:0]] = cur_sel + 1'b1;
            end else begin
               if (!key_eq) begin
                  all_eq_in = 1'b0;
               end
               sel_in = sel_last ? CW'(sid_ff) : CW'(sel_ff + 1'b1);
            end
         end
         S_FINISH: begin
            // sel points at the shortest list here
            cur_in[sel_ff[LW-1:0]] = LENW'(pos_ff + 1'b1);
            if (all_eq_ff) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = 1'b1;
               rsp_idx_in   = MATCH_IDX_W'(pos_ff);
            end
         end
         default: begin
         end
      endcase

      rsp_sl_in = SHORT_LIST_W'(sid_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         lists_in_use_ff <= '0;
         for (int i = 0; i < MAX_LISTS; i++) begin
            len_ff[i] <= '0;
            cur_ff[i] <= '0;
         end
         sid_ff          <= '0;
         slen_ff         <= '0;
         started_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         lists_in_use_ff <= lists_in_use_in;
         len_ff          <= len_in;
         cur_ff          <= cur_in;
         sid_ff          <= sid_in;
         slen_ff         <= slen_in;
         started_ff      <= started_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      pos_ff      <= pos_in;
      probe_ff    <= probe_in;
      all_eq_ff   <= all_eq_in;
      key_ff      <= key_in;
      id_bad_ff   <= id_bad_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_sl_ff   <= rsp_sl_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_done_ff <= rsp_done_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   sli_key_ram #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (key_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_index   = rsp_idx_ff;
   assign rsp_shortest_list = rsp_sl_ff;
   assign rsp_match_valid   = rsp_mv_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

>>> rtl/sli_key_ram.sv
// Key store for the sorted list intersection block.
// Single write port, single registered read port.
// Depends on sli_pkg for the key width.
module sli_key_ram #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [sli_pkg::KEY_W-1:0] wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [sli_pkg::KEY_W-1:0] rd_data
);
   import sli_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_list_intersection: directed and random request items checked
// against an in-bench model of list loading, shortest-list pick and cursor walk.
// Depends on sli_pkg and the RTL top level only.
module tb;
   import sli_pkg::*;

   localparam int NUM_LISTS     = 8;
   localparam int LIST_CAP      = 1024;
   localparam int ITEM_TARGET   = 450;     // request items queued over the whole run
   localparam int SETTLE_CYCLES = 4;       // quiet cycles before a csr write or the end of a drain
   localparam int TAIL_CYCLES   = 40;      // hold-off once every result is back
   localparam int STALL_LIMIT   = 200000;  // cycles with no handshake at all
   localparam int REPORT_LIMIT  = 10;

   // what the driver queue holds: a request item, a lists_in_use write, or a pause
   typedef enum logic [1:0] {
      SLOT_REQ,
      SLOT_CSR,
      SLOT_DRAIN
   } slot_kind_type;

   typedef struct {
      slot_kind_type              kind;
      logic [REQ_TYPE_W-1:0]      req_type;
      logic [LIST_ID_W-1:0]       list_id;
      logic [KEY_W-1:0]           key;
      logic [CSR_W-1:0]           cfg;
   } slot_type;

   typedef struct packed {
      logic [MATCH_IDX_W-1:0]     match_index;
      logic [SHORT_LIST_W-1:0]    shortest_list;
      logic                       match_valid;
      logic                       done_res;
      logic                       overflow;
   } rsp_type;

   // ---------------------------------------------------------------- DUT
   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       start         = 1'b0;
   logic                       busy;
   logic [REQ_TYPE_W-1:0]      req_type      = '0;
   logic [LIST_ID_W-1:0]       req_list_id   = '0;
   logic [KEY_W-1:0]           req_key_value = '0;
   logic                       rsp_valid;
   logic [MATCH_IDX_W-1:0]     rsp_match_index;
   logic [SHORT_LIST_W-1:0]    rsp_shortest_list;
   logic                       rsp_match_valid;
   logic                       rsp_done_res;
   logic                       rsp_overflow;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_W-1:0]           csr_data      = '0;

   sorted_list_intersection #(
      .MAX_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_CAP)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_list_id       (req_list_id),
      .req_key_value     (req_key_value),
      .rsp_valid         (rsp_valid),
      .rsp_match_index   (rsp_match_index),
      .rsp_shortest_list (rsp_shortest_list),
      .rsp_match_valid   (rsp_match_valid),
      .rsp_done_res      (rsp_done_res),
      .rsp_overflow      (rsp_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- shared bench state
   slot_type   pending_slots[$];
   rsp_type    expected_rsps[$];
   slot_type   on_port;                 // item currently presented on req_*
   int         items_accepted = 0;      // written with NBA by the driver
   int         results_seen   = 0;      // written with NBA by the monitor
   logic       driver_idle    = 1'b0;   // NBA: nothing queued, nothing presented
   int         stall_cycles   = 0;
   int         mismatch_count = 0;
   int         items_queued   = 0;
   logic [CSR_W-1:0] gen_cfg  = '0;     // lists_in_use as the generator will leave it

   // sender burst shaping
   int         burst_left = 1;
   int         gap_left   = 0;
   int         settle     = 0;

   // ---------------------------------------------------------------- intersection model
   // Own copy of the lists, cursors and shortest-list choice.
   logic [KEY_W-1:0]     key_mem [NUM_LISTS][LIST_CAP];
   int unsigned          len_of  [NUM_LISTS];
   int unsigned          cur_of  [NUM_LISTS];
   logic [SHORT_LIST_W-1:0] short_id  = '0;
   int unsigned          short_len = 0;
   logic                 scanning  = 1'b0;
   logic [CSR_W-1:0]     lists_cfg = '0;

   initial begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         len_of[i] = 0;
         cur_of[i] = 0;
      end
   end

   // an append, a clear or a csr write throws away any scan in progress
   function automatic void rewind_cursors();
      for (int i = 0; i < NUM_LISTS; i++) cur_of[i] = 0;
      scanning = 1'b0;
   endfunction

   function automatic void apply_lists_cfg(input logic [CSR_W-1:0] value);
      lists_cfg = value;
      rewind_cursors();
   endfunction

   function automatic rsp_type predict_response(input slot_type it);
      rsp_type          r;
      int unsigned      n;
      int unsigned      pos;
      int unsigned      len;
      logic [KEY_W-1:0] probe;
      logic             empty;
      logic             found;
      logic             all_eq;
      r = '0;
      // settings past the list count behave as the full set
      n = (lists_cfg > NUM_LISTS) ? NUM_LISTS : 32'(lists_cfg);
      case (it.req_type)
         REQ_CLEAR: begin
            for (int i = 0; i < NUM_LISTS; i++) len_of[i] = 0;
            rewind_cursors();
            short_id  = '0;
            short_len = 0;
         end
         REQ_APPEND: begin
            // a 3-bit id always names a real list, so only a full list drops the key
            if (len_of[it.list_id] >= LIST_CAP) begin
               r.overflow = 1'b1;
            end else begin
               key_mem[it.list_id][len_of[it.list_id]] = it.key;
               len_of[it.list_id]++;
            end
            rewind_cursors();
         end
         REQ_FETCH: begin
            empty = (n == 0);
            for (int i = 0; i < n; i++)
               if (len_of[i] == 0) empty = 1'b1;
            if (empty) begin
               r.done_res = 1'b1;
            end else begin
               if (!scanning) begin
                  // shortest list, strict compare so the lowest id keeps a tie
                  short_id  = '0;
                  short_len = len_of[0];
                  for (int i = 1; i < n; i++) begin
                     if (len_of[i] < short_len) begin
                        short_len = len_of[i];
                        short_id  = SHORT_LIST_W'(i);
                     end
                  end
                  for (int i = 0; i < NUM_LISTS; i++) cur_of[i] = 0;
                  scanning = 1'b1;
               end
               found = 1'b0;
               while (!found && cur_of[short_id] < short_len) begin
                  pos    = cur_of[short_id];
                  probe  = key_mem[short_id][pos];
                  all_eq = 1'b1;
                  for (int i = 0; i < n; i++) begin
                     len = len_of[i];
                     // bound checked before the key is read
                     while (cur_of[i] < len && key_mem[i][cur_of[i]] < probe) cur_of[i]++;
                     if (cur_of[i] >= len || key_mem[i][cur_of[i]] > probe) all_eq = 1'b0;
                  end
                  cur_of[short_id] = pos + 1;
                  if (all_eq) begin
                     found         = 1'b1;
                     r.match_index = pos[MATCH_IDX_W-1:0];
                  end
               end
               if (found) r.match_valid = 1'b1;
               else       r.done_res    = 1'b1;
            end
         end
         default: ;   // no-op changes nothing
      endcase
      r.shortest_list = short_id;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus queue helpers
   task automatic queue_request(input logic [REQ_TYPE_W-1:0] t, input int id,
                                input logic [KEY_W-1:0] key);
      slot_type s;
      s.kind     = SLOT_REQ;
      s.req_type = t;
      s.list_id  = LIST_ID_W'(id);
      s.key      = key;
      s.cfg      = '0;
      pending_slots = {pending_slots, s};
      items_queued++;
   endtask

   task automatic queue_lists_cfg(input logic [CSR_W-1:0] value);
      slot_type s;
      s.kind     = SLOT_CSR;
      s.req_type = REQ_NOP;
      s.list_id  = '0;
      s.key      = '0;
      s.cfg      = value;
      pending_slots = {pending_slots, s};
      gen_cfg = value;
   endtask

   task automatic queue_drain();
      slot_type s;
      s.kind     = SLOT_DRAIN;
      s.req_type = REQ_NOP;
      s.list_id  = '0;
      s.key      = '0;
      s.cfg      = '0;
      pending_slots = {pending_slots, s};
   endtask

   function automatic logic [KEY_W-1:0] any_key();
      return {$urandom, $urandom};
   endfunction

   // One random phase: mostly a well-formed load of ascending lists drawn from a
   // shared pool of keys, then fetches, with stray items and mid-scan appends mixed in.
   task automatic add_random_phase();
      int               n_lists;
      int               pool_len;
      int               density;
      int               fetches;
      int               pick;
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] key_stride;
      logic [KEY_W-1:0] kv;
      if ($urandom_range(0, 3) == 0) queue_drain();
      if ($urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)      queue_lists_cfg(CSR_W'($urandom_range(1, NUM_LISTS)));
         else if (pick < 8) queue_lists_cfg('0);
         else               queue_lists_cfg(CSR_W'($urandom_range(NUM_LISTS + 1, 15)));
      end
      if ($urandom_range(0, 9) != 0) queue_request(REQ_CLEAR, $urandom_range(0, 7), any_key());
      n_lists = (gen_cfg > NUM_LISTS) ? NUM_LISTS : int'(gen_cfg);
      if (n_lists == 0) n_lists = $urandom_range(1, 3);
      pool_len   = $urandom_range(1, 12);
      base       = any_key();
      key_stride = KEY_W'($urandom_range(1, 3));
      for (int l = 0; l < n_lists; l++) begin
         if ($urandom_range(0, 19) == 0) continue;   // leave this list empty
         density = $urandom_range(50, 100);
         for (int k = 0; k < pool_len; k++) begin
            kv = base + key_stride * KEY_W'(k);
            if ($urandom_range(1, 100) <= density) queue_request(REQ_APPEND, l, kv);
         end
      end
      fetches = $urandom_range(1, pool_len + 2);
      for (int k = 0; k < fetches; k++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            queue_request(REQ_TYPE_W'($urandom_range(0, 3)), $urandom_range(0, 7), any_key());
         else if (pick == 1)
            queue_request(REQ_APPEND, $urandom_range(0, 7), any_key());
         queue_request(REQ_FETCH, $urandom_range(0, 7), any_key());
      end
   endtask

   // ---------------------------------------------------------------- driver
   // Presents queued items with start, holds them until accepted (start && !busy),
   // and predicts each one at its accept edge. Csr writes and drains wait until
   // every outstanding result has come back and the block has been quiet a while.
   always @(posedge clock) begin : driver
      slot_type head;
      rsp_type  predicted;
      logic     keep_start;
      logic     keep_csr;
      if (reset) begin
         start       <= 1'b0;
         csr_valid   <= 1'b0;
         driver_idle <= 1'b0;
         settle       = 0;
      end else begin
         if (start && !busy) begin
            predicted     = predict_response(on_port);
            expected_rsps = {expected_rsps, predicted};
            items_accepted <= items_accepted + 1;
         end
         if (csr_valid && csr_ready) apply_lists_cfg(csr_data);

         keep_start = start && busy;
         keep_csr   = csr_valid && !csr_ready;

         if (!start && !csr_valid && items_accepted <= results_seen) settle = settle + 1;
         else settle = 0;

         if (!keep_start && !keep_csr && pending_slots.size() != 0) begin
            head = pending_slots[0];
            case (head.kind)
               SLOT_REQ: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     void'(pending_slots.pop_front());
                     on_port        = head;
                     req_type      <= head.req_type;
                     req_list_id   <= head.list_id;
                     req_key_value <= head.key;
                     keep_start     = 1'b1;
                     burst_left--;
                     if (burst_left <= 0) begin
                        if ($urandom_range(0, 4) == 0) begin
                           // stretch with no idling at all
                           burst_left = $urandom_range(20, 64);
                           gap_left   = 0;
                        end else begin
                           burst_left = $urandom_range(1, 16);
                           gap_left   = $urandom_range(1, 12);
                        end
                     end
                  end
               end
               SLOT_CSR: begin
                  if (settle >= SETTLE_CYCLES) begin
                     void'(pending_slots.pop_front());
                     csr_data <= head.cfg;
                     keep_csr  = 1'b1;
                  end
               end
               SLOT_DRAIN: begin
                  if (settle >= SETTLE_CYCLES) void'(pending_slots.pop_front());
               end
               default: void'(pending_slots.pop_front());
            endcase
         end

         start       <= keep_start;
         csr_valid   <= keep_csr;
         driver_idle <= (pending_slots.size() == 0) && !keep_start && !keep_csr;
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] %s: exp idx=%0d list=%0d match=%0d done=%0d ovf=%0d",
                  $realtime, what,
                  want.match_index, want.shortest_list, want.match_valid,
                  want.done_res, want.overflow);
         $display("      got idx=%0d list=%0d match=%0d done=%0d ovf=%0d",
                  got.match_index, got.shortest_list, got.match_valid,
                  got.done_res, got.overflow);
      end
   endtask

   // Results cannot be held off: take every strobe and check it against the oldest
   // prediction, each field on its own.
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_match_index, rsp_shortest_list, rsp_match_valid, rsp_done_res,
                rsp_overflow};
         results_seen <= results_seen + 1;
         if (expected_rsps.size() == 0) begin
            log_mismatch("result with nothing expected", '0, got);
         end else begin
            want = expected_rsps.pop_front();
            if (got.match_index   !== want.match_index   ||
                got.shortest_list !== want.shortest_list ||
                got.match_valid   !== want.match_valid   ||
                got.done_res      !== want.done_res      ||
                got.overflow      !== want.overflow)
               log_mismatch("result mismatch", want, got);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   // ---------------------------------------------------------------- test sequence
   initial begin : test_seq
      logic             timed_out;

      // --- directed: empty setup, every request code, key extremes
      queue_request(REQ_FETCH, 0, '0);                 // nothing in use -> done
      queue_request(REQ_NOP, 7, '1);
      queue_lists_cfg(4'd2);
      queue_request(REQ_APPEND, 0, 64'd0);
      queue_request(REQ_APPEND, 0, 64'd5);
      queue_request(REQ_APPEND, 0, '1);
      queue_request(REQ_APPEND, 1, 64'd5);
      queue_request(REQ_APPEND, 1, '1);
      queue_request(REQ_APPEND, 7, 64'h8000_0000_0000_0000);   // list not in use
      queue_request(REQ_FETCH, 5, 64'h5555_5555_5555_5555);
      queue_request(REQ_FETCH, 2, 64'hAAAA_AAAA_AAAA_AAAA);
      // append mid-scan: cursors restart, lengths now tie so list 0 wins
      queue_request(REQ_APPEND, 1, '1);
      queue_request(REQ_FETCH, 0, '0);
      queue_request(REQ_FETCH, 0, '0);
      queue_request(REQ_FETCH, 0, '0);
      queue_request(REQ_FETCH, 0, '0);                 // past the end -> done again
      queue_drain();
      queue_lists_cfg(4'd8);                           // reconfigure; lists 2..6 are empty
      queue_request(REQ_FETCH, 3, '0);
      queue_lists_cfg(4'd15);                          // above the list count
      queue_request(REQ_FETCH, 6, '1);
      queue_lists_cfg(4'd0);
      queue_request(REQ_FETCH, 1, '0);
      queue_request(REQ_CLEAR, 6, '1);
      queue_lists_cfg(4'd1);
      queue_request(REQ_FETCH, 0, '0);                 // list 0 empty after clear

      // --- random phases up to the item budget
      while (items_queued < ITEM_TARGET) add_random_phase();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to empty and every result to come back
      while (!(driver_idle && items_accepted <= results_seen) && stall_cycles < STALL_LIMIT)
         @(posedge clock);
      timed_out = (stall_cycles >= STALL_LIMIT);
      if (!timed_out) repeat (TAIL_CYCLES) @(posedge clock);

      if (!timed_out && mismatch_count == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
